@@ hw/rtl/tcce_pkg.sv @@
`timescale 1ns / 1ps

package tcce_pkg;

    localparam logic [1:0] CMD_PUT_CHAR   = 2'd0;
    localparam logic [1:0] CMD_CLEAR      = 2'd1;
    localparam logic [1:0] CMD_SET_CURSOR = 2'd2;
    localparam logic [1:0] CMD_READ_CELL  = 2'd3;

    localparam logic [7:0] CHR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHR_RETURN    = 8'h0D;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHR_BLANK     = 8'h20;

    localparam logic [15:0] RESET_CELL    = 16'h0720;
    localparam logic [7:0]  RESET_ATTR    = 8'h07;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [6:0]  set_column;
        logic [4:0]  set_line;
        logic [10:0] cell_index;
    } cmd_word_t;

    typedef struct packed {
        logic [6:0]  cursor_column;
        logic [4:0]  cursor_line;
        logic [10:0] cursor_position;
        logic [15:0] cell_value;
        logic        scrolled;
    } rsp_word_t;

endpackage

@@ hw/rtl/text_console_cursor_engine_core.sv @@
`timescale 1ns / 1ps
// Sequence: a word is taken in ST_IDLE and run in ST_EXEC; a cell read in range passes ST_READ,
// a scroll copies rows up in ST_SCROLL and blanks the last line in ST_FILL, and a clear fills
// every cell in ST_FILL; ST_DONE then loads the result into the output register. One word is in
// flight; the next word is taken while the previous result waits in the output register.
// Reset: cursor 0,0, attribute 0x07, then ST_INIT writes 0x0720 to every cell
// with cmd_stall high; configuration writes are taken throughout.

module text_console_cursor_engine_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  tcce_pkg::cmd_word_t  cmd_word,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tcce_pkg::rsp_word_t  rsp_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int MOVE_CELLS = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int CNT_W      = $clog2(CELLS + 1);
    localparam int COL_W      = $clog2(COLUMNS + 8);
    localparam int ROW_W      = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    tcce_pkg::cmd_word_t cmd_reg, cmd_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [7:0]          attr_reg, attr_next;
    logic [15:0]         value_reg, value_next;
    logic                scrolled_reg, scrolled_next;
    logic                wp_reg, wp_next;
    logic [ADDR_W-1:0]   wp_addr_reg, wp_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    tcce_pkg::rsp_word_t rsp_reg, rsp_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;

    logic [ADDR_W-1:0] cur_addr;
    logic [15:0]       blank;
    logic [COL_W-1:0]  col_p;
    logic [ROW_W-1:0]  row_p;
    logic              put_wr_en;
    logic [ADDR_W-1:0] put_wr_addr;
    logic [15:0]       put_wr_data;
    logic [COL_W+6:0]  col_wide;
    logic [ROW_W+4:0]  row_wide;
    logic [ADDR_W+10:0] pos_wide;
    logic [ADDR_W+10:0] idx_wide;

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_addr  = ADDR_W'(row_reg * COLUMNS + col_reg);
    assign blank     = {attr_reg, tcce_pkg::CHR_BLANK};
    assign col_wide  = {7'd0, col_reg};
    assign row_wide  = {5'd0, row_reg};
    assign pos_wide  = {11'd0, cur_addr};
    assign idx_wide  = {ADDR_W'(0), cmd_reg.cell_index};

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    // put character: cursor motion and cell write
    always_comb
    begin
        col_p       = col_reg;
        row_p       = row_reg;
        put_wr_en   = 1'b0;
        put_wr_addr = cur_addr;
        put_wr_data = {attr_reg, cmd_reg.char_code};
        unique case (cmd_reg.char_code)
            tcce_pkg::CHR_NEWLINE:
            begin
                col_p = '0;
                row_p = row_reg + ROW_W'(1);
            end
            tcce_pkg::CHR_RETURN:
            begin
                col_p = '0;
            end
            tcce_pkg::CHR_TAB:
            begin
                col_p = (col_reg + COL_W'(8)) & ~COL_W'(7);
            end
            tcce_pkg::CHR_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_p       = col_reg - COL_W'(1);
                    put_wr_en   = 1'b1;
                    put_wr_addr = cur_addr - ADDR_W'(1);
                    put_wr_data = blank;
                end
            end
            default:
            begin
                col_p     = col_reg + COL_W'(1);
                put_wr_en = 1'b1;
            end
        endcase
        if (col_p >= COL_W'(COLUMNS))
        begin
            col_p = '0;
            row_p = row_p + ROW_W'(1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        attr_next      = attr_reg;
        value_next     = value_reg;
        scrolled_next  = scrolled_reg;
        wp_next        = wp_reg;
        wp_addr_next   = wp_addr_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (cfg_valid && cfg_ready)
        begin
            attr_next = cfg_data;
        end
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = tcce_pkg::RESET_CELL;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd_word;
                    value_next    = '0;
                    scrolled_next = 1'b0;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (cmd_reg.command)
                    tcce_pkg::CMD_PUT_CHAR:
                    begin
                        wr_en    = put_wr_en;
                        wr_addr  = put_wr_addr;
                        wr_data  = put_wr_data;
                        col_next = col_p;
                        if (row_p >= ROW_W'(ROWS))
                        begin
                            row_next      = ROW_W'(ROWS - 1);
                            scrolled_next = 1'b1;
                            cnt_next      = '0;
                            wp_next       = 1'b0;
                            state_next    = ST_SCROLL;
                        end
                        else
                        begin
                            row_next   = row_p;
                            state_next = ST_DONE;
                        end
                    end
                    tcce_pkg::CMD_CLEAR:
                    begin
                        col_next   = '0;
                        row_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_FILL;
                    end
                    tcce_pkg::CMD_SET_CURSOR:
                    begin
                        col_next = (cmd_reg.set_column >= 7'(COLUMNS)) && (COLUMNS < 128)
                                 ? COL_W'(COLUMNS - 1) : COL_W'(cmd_reg.set_column);
                        row_next = (32'(cmd_reg.set_line) >= ROWS)
                                 ? ROW_W'(ROWS - 1) : ROW_W'(cmd_reg.set_line);
                        state_next = ST_DONE;
                    end
                    tcce_pkg::CMD_READ_CELL:
                    begin
                        if (idx_wide < (ADDR_W + 11)'(CELLS))
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = idx_wide[ADDR_W-1:0];
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ:
            begin
                value_next = rd_data;
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                if (wp_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wp_addr_reg;
                    wr_data = rd_data;
                end
                if (cnt_reg < CNT_W'(MOVE_CELLS))
                begin
                    rd_en        = 1'b1;
                    rd_addr      = ADDR_W'(cnt_reg + COLUMNS);
                    wp_next      = 1'b1;
                    wp_addr_next = cnt_reg[ADDR_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    wp_next    = 1'b0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
                wr_data = blank;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_next.cursor_column   = col_wide[6:0];
                    rsp_next.cursor_line     = row_wide[4:0];
                    rsp_next.cursor_position = pos_wide[10:0];
                    rsp_next.cell_value      = value_reg;
                    rsp_next.scrolled        = scrolled_reg;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            cmd_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= tcce_pkg::RESET_ATTR;
            value_reg     <= '0;
            scrolled_reg  <= 1'b0;
            wp_reg        <= 1'b0;
            wp_addr_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            attr_reg      <= attr_next;
            value_reg     <= value_next;
            scrolled_reg  <= scrolled_next;
            wp_reg        <= wp_next;
            wp_addr_reg   <= wp_addr_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("screen write while idle");

    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg < ROW_W'(ROWS)) && (col_reg < COL_W'(COLUMNS)))
        else $error("cursor outside screen");

    a_scroll_last_line: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.scrolled) |-> (rsp_reg.cursor_line == 5'(ROWS - 1)))
        else $error("scroll reported away from last line");

    a_scroll_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL && wr_en && rd_en) |-> (rd_addr > wr_addr))
        else $error("scroll copy overtakes its source");

endmodule

@@ hw/rtl/tcce_ram.sv @@
`timescale 1ns / 1ps

module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
